/* src/sri_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sri_pkg
// Shared types and constants of the synonym record sample indexer.
// ----------------------------------------------------------------------------
package sri_pkg;

   // field widths
   localparam int BYTE_W     = 8;
   localparam int OFFSET_W   = 32;
   localparam int COUNT_W    = 32;
   localparam int INTERVAL_W = 16;
   localparam int MAX_LEN_W  = 8;
   localparam int ALIAS_W    = 9;
   localparam int SUFFIX_W   = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // record layout
   localparam logic [SUFFIX_W-1:0] SUFFIX_BYTES = 3'd4;

   // register reset values
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd64;
   localparam logic [MAX_LEN_W-1:0]  MAX_LEN_RESET  = 8'd255;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_INTERVAL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ALIAS_LEN   = 1'b1;

   // result kinds
   localparam logic KIND_SAMPLE  = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // scan status codes
   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_MALFORMED = 1'b1;

   // default depth of the queue between scanner and emitter
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // one queued step: an optional sample followed by an optional summary
   typedef struct packed {
      logic                smp_vld;
      logic                sum_vld;
      logic [OFFSET_W-1:0] offset;
      logic [COUNT_W-1:0]  count;
      logic                status;
   } step_type;

endpackage

/* src/sri_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sri_scan
// Front end: takes one file byte per beat, tracks record structure and
// queues the sample and summary results that the byte produces.
// ----------------------------------------------------------------------------
module sri_scan (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                q_full,
   input  logic [sri_pkg::BYTE_W-1:0]          req_data_byte,
   input  logic                                req_start_of_file,
   input  logic                                req_end_of_file,
   input  logic                                csr_write_en,
   input  logic [sri_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sri_pkg::CSR_DATA_W-1:0]      csr_write_data,
   output logic                                push,
   output sri_pkg::step_type                   push_step
);

   // configuration
   logic [sri_pkg::INTERVAL_W-1:0] interval_ff, interval_in;
   logic [sri_pkg::MAX_LEN_W-1:0]  max_len_ff, max_len_in;

   // scan state
   logic [sri_pkg::OFFSET_W-1:0]   pos_ff, pos_in;
   logic [sri_pkg::ALIAS_W-1:0]    alias_ff, alias_in;
   logic [sri_pkg::SUFFIX_W-1:0]   suffix_ff, suffix_in;
   logic [sri_pkg::INTERVAL_W-1:0] recs_ff, recs_in;
   logic [sri_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic                           bad_ff, bad_in;

   logic                           accept;
   logic                           smp_mid;
   logic [sri_pkg::OFFSET_W-1:0]   mid_offset;

   assign accept = req_valid && !q_full;

   // register writes
   always_comb begin
      interval_in = interval_ff;
      max_len_in  = max_len_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            sri_pkg::CSR_SAMPLE_INTERVAL: interval_in = csr_write_data;
            sri_pkg::CSR_MAX_ALIAS_LEN:
               max_len_in = csr_write_data[sri_pkg::MAX_LEN_W-1:0];
            default: interval_in = interval_ff;
         endcase
      end
   end

   // per-byte scan step
   always_comb begin
      pos_in     = req_start_of_file ? '0 : pos_ff;
      alias_in   = req_start_of_file ? '0 : alias_ff;
      suffix_in  = req_start_of_file ? '0 : suffix_ff;
      recs_in    = req_start_of_file ? '0 : recs_ff;
      count_in   = req_start_of_file ? sri_pkg::COUNT_W'(1) : count_ff;
      bad_in     = req_start_of_file ? 1'b0 : bad_ff;
      smp_mid    = 1'b0;
      mid_offset = '0;

      if (!bad_in) begin
         if (suffix_in == '0) begin
            if (req_data_byte == '0) begin
               // terminator: alias must be non-empty and within limit
               if (alias_in == '0 || alias_in > {1'b0, max_len_ff}) begin
                  bad_in = 1'b1;
               end else begin
                  suffix_in = sri_pkg::SUFFIX_BYTES;
               end
            end else begin
               alias_in = alias_in + sri_pkg::ALIAS_W'(1);
               if (alias_in > {1'b0, max_len_ff}) begin
                  bad_in = 1'b1;
               end
            end
         end else begin
            suffix_in = suffix_in - sri_pkg::SUFFIX_W'(1);
            // record complete
            if (suffix_in == '0) begin
               alias_in = '0;
               recs_in  = recs_in + sri_pkg::INTERVAL_W'(1);
               if (recs_in == interval_ff) begin
                  recs_in = '0;
                  if (!req_end_of_file) begin
                     count_in   = count_in + sri_pkg::COUNT_W'(1);
                     smp_mid    = 1'b1;
                     mid_offset = pos_in + sri_pkg::OFFSET_W'(1);
                  end
               end
            end
         end
      end

      pos_in = pos_in + sri_pkg::OFFSET_W'(1);

      // unfinished record at end of file
      if (req_end_of_file && (alias_in != '0 || suffix_in != '0)) begin
         bad_in = 1'b1;
      end
   end

   // queued step
   always_comb begin
      push_step.smp_vld = req_start_of_file || smp_mid;
      push_step.sum_vld = req_end_of_file;
      push_step.offset  = mid_offset;
      push_step.count   = count_in;
      push_step.status  = bad_in ? sri_pkg::STATUS_MALFORMED : sri_pkg::STATUS_OK;
      push = accept && (req_start_of_file || req_end_of_file || smp_mid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= sri_pkg::INTERVAL_RESET;
         max_len_ff  <= sri_pkg::MAX_LEN_RESET;
         pos_ff      <= '0;
         alias_ff    <= '0;
         suffix_ff   <= '0;
         recs_ff     <= '0;
         count_ff    <= '0;
         bad_ff      <= 1'b0;
      end else begin
         interval_ff <= interval_in;
         max_len_ff  <= max_len_in;
         if (accept) begin
            pos_ff    <= pos_in;
            alias_ff  <= alias_in;
            suffix_ff <= suffix_in;
            recs_ff   <= recs_in;
            count_ff  <= count_in;
            bad_ff    <= bad_in;
         end
      end
   end

endmodule

/* src/sri_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sri_queue
// Short register queue of scan steps between the scanner and the emitter.
// ----------------------------------------------------------------------------
module sri_queue #(
   parameter int DEPTH = sri_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sri_pkg::step_type push_step,
   input  logic              pop,
   output sri_pkg::step_type head_step,
   output logic              empty,
   output logic              full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sri_pkg::step_type  slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic               do_push, do_pop;

   assign empty     = (fill_ff == '0);
   assign full      = (fill_ff == CNT_W'(DEPTH));
   assign head_step = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_step;
      end
   end

endmodule

/* src/sri_emit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sri_emit
// Back end: expands each queued step into its result beats and holds them
// in the output register until the receiver takes them.
// ----------------------------------------------------------------------------
module sri_emit (
   input  logic                             clock,
   input  logic                             reset,
   input  sri_pkg::step_type                head_step,
   input  logic                             q_empty,
   output logic                             pop,
   input  logic                             rsp_stall,
   output logic                             rsp_valid,
   output logic                             rsp_result_kind,
   output logic [sri_pkg::OFFSET_W-1:0]     rsp_record_offset,
   output logic [sri_pkg::COUNT_W-1:0]      rsp_samples_total,
   output logic                             rsp_scan_status,
   output logic                             rsp_last_result
);

   logic                          valid_ff, valid_in;
   logic                          phase_ff, phase_in;
   logic                          kind_ff, kind_in;
   logic [sri_pkg::OFFSET_W-1:0]  offset_ff, offset_in;
   logic [sri_pkg::COUNT_W-1:0]   total_ff, total_in;
   logic                          status_ff, status_in;
   logic                          last_ff, last_in;
   logic                          take;

   // output register free or being drained this cycle
   assign take = !valid_ff || !rsp_stall;

   // pick the next beat: sample first, then summary
   always_comb begin
      valid_in  = valid_ff;
      phase_in  = phase_ff;
      kind_in   = kind_ff;
      offset_in = offset_ff;
      total_in  = total_ff;
      status_in = status_ff;
      last_in   = last_ff;
      pop       = 1'b0;
      if (take) begin
         valid_in = !q_empty;
         if (!q_empty) begin
            total_in = head_step.count;
            if (!phase_ff && head_step.smp_vld) begin
               kind_in   = sri_pkg::KIND_SAMPLE;
               offset_in = head_step.offset;
               status_in = sri_pkg::STATUS_OK;
               last_in   = !head_step.sum_vld;
               phase_in  = head_step.sum_vld;
               pop       = !head_step.sum_vld;
            end else begin
               kind_in   = sri_pkg::KIND_SUMMARY;
               offset_in = '0;
               status_in = head_step.status;
               last_in   = 1'b1;
               phase_in  = 1'b0;
               pop       = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      offset_ff <= offset_in;
      total_ff  <= total_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_result_kind   = kind_ff;
   assign rsp_record_offset = offset_ff;
   assign rsp_samples_total = total_ff;
   assign rsp_scan_status   = status_ff;
   assign rsp_last_result   = last_ff;

endmodule

/* src/synonym_record_sample_indexer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// synonym_record_sample_indexer_top
// Scans a synonym file byte by byte, emitting sampled record offsets and an
// end-of-file summary with sample count and well-formedness status.
//
//   channel   direction  handshake            beat
//   req_      in         req_valid/req_stall  one file byte with start/end marks
//   rsp_      out        rsp_valid/rsp_stall  one sample or summary result
//   csr_      in         csr_write_en         register write, no wait
//
// One byte is taken every cycle while the step queue has room.
// A byte's first result passes through the step queue into the output register;
// a byte with two results holds the output register for its sample, then its summary.
// req_stall rises only when the step queue is full, after rsp_stall or a run
// of bytes with two results each.
// Synchronous reset restores registers to 64 / 255 and clears scan state.
// ----------------------------------------------------------------------------
module synonym_record_sample_indexer_top #(
   parameter int QUEUE_DEPTH = sri_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [sri_pkg::BYTE_W-1:0]        req_data_byte,
   input  logic                              req_start_of_file,
   input  logic                              req_end_of_file,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_result_kind,
   output logic [sri_pkg::OFFSET_W-1:0]      rsp_record_offset,
   output logic [sri_pkg::COUNT_W-1:0]       rsp_samples_total,
   output logic                              rsp_scan_status,
   output logic                              rsp_last_result,
   input  logic                              csr_write_en,
   input  logic [sri_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sri_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   logic              push, pop, q_empty, q_full;
   sri_pkg::step_type push_step, head_step;

   assign req_stall = q_full;

   // front end
   sri_scan u_scan (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .q_full            (q_full),
      .req_data_byte     (req_data_byte),
      .req_start_of_file (req_start_of_file),
      .req_end_of_file   (req_end_of_file),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .push              (push),
      .push_step         (push_step)
   );

   // step queue
   sri_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_step (push_step),
      .pop       (pop),
      .head_step (head_step),
      .empty     (q_empty),
      .full      (q_full)
   );

   // back end
   sri_emit u_emit (
      .clock             (clock),
      .reset             (reset),
      .head_step         (head_step),
      .q_empty           (q_empty),
      .pop               (pop),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_record_offset (rsp_record_offset),
      .rsp_samples_total (rsp_samples_total),
      .rsp_scan_status   (rsp_scan_status),
      .rsp_last_result   (rsp_last_result)
   );

endmodule
